/* hw/rtl/fac_pkg.sv */
package fac_pkg;

    // Each matrix entry is a signed 16-bit fixed-point value.
    localparam int ENTRY_BITS     = 16;
    // The sum or difference of two entries needs one more bit.
    localparam int NORMAL_BITS    = ENTRY_BITS + 1;
    localparam int ROW_BITS       = 4 * ENTRY_BITS;
    localparam int ROW_ENTRIES    = 4;
    localparam int AXES           = 3;
    localparam int PLANE_COUNT    = 6;
    // Fractional bits of the box coordinates; the plane offset is aligned to them.
    localparam int COORD_FRAC     = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int M_TDATA_BITS   = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_X = 2'd0,
        CFG_ROW_Y = 2'd1,
        CFG_ROW_Z = 2'd2,
        CFG_ROW_W = 2'd3
    } cfg_index_t;

    // Identity matrix, one entry of 1.0 on the diagonal of each row.
    localparam logic [ROW_BITS-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_BITS-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_BITS-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;
    localparam logic [ROW_BITS-1:0] ROW_W_RESET = 64'h0100_0000_0000_0000;

    typedef logic signed [NORMAL_BITS-1:0] normal_t;

    // Plane coefficients: x, y and z normal components, then the offset.
    typedef normal_t plane_t [ROW_ENTRIES];

    typedef struct packed {
        logic load_mul;
        logic load_sum;
    } pipe_ctrl_t;

    // One coefficient of a clip plane: row w plus or minus another row.
    function automatic normal_t plane_coef(
        input logic [ROW_BITS-1:0] row_w,
        input logic [ROW_BITS-1:0] row_o,
        input logic [1:0]          col,
        input logic                add
    );
        logic signed [ENTRY_BITS-1:0] a;
        logic signed [ENTRY_BITS-1:0] b;
        a = $signed(row_w[ENTRY_BITS*col +: ENTRY_BITS]);
        b = $signed(row_o[ENTRY_BITS*col +: ENTRY_BITS]);
        if (add) begin
            return NORMAL_BITS'(a) + NORMAL_BITS'(b);
        end else begin
            return NORMAL_BITS'(a) - NORMAL_BITS'(b);
        end
    endfunction

endpackage

/* hw/rtl/fac_plane.sv */
module fac_plane
    import fac_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          aclk,
    input  pipe_ctrl_t                    ctrl,
    input  normal_t                       normal [ROW_ENTRIES],
    input  logic signed [COORD_WIDTH:0]   vp     [AXES],
    input  logic signed [COORD_WIDTH:0]   vm     [AXES],
    output logic                          above
);

    localparam int PROD_W = NORMAL_BITS + COORD_WIDTH + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int DIST_W = SUM_W + 1;

    logic signed [PROD_W-1:0] prod_next [AXES];
    logic signed [PROD_W-1:0] prod_reg  [AXES];
    normal_t                  offset_reg;
    logic signed [SUM_W-1:0]  sum_a_next;
    logic signed [SUM_W-1:0]  sum_b_next;
    logic signed [SUM_W-1:0]  sum_a_reg;
    logic signed [SUM_W-1:0]  sum_b_reg;
    logic signed [DIST_W-1:0] distance;

    // The positive vertex: each half extent follows the sign of its normal component.
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            if (normal[k][NORMAL_BITS-1]) begin
                prod_next[k] = PROD_W'(normal[k]) * PROD_W'(vm[k]);
            end else begin
                prod_next[k] = PROD_W'(normal[k]) * PROD_W'(vp[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_mul) begin
            prod_reg   <= prod_next;
            offset_reg <= normal[ROW_ENTRIES-1];
        end
    end

    always_comb begin
        sum_a_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
        sum_b_next = SUM_W'(prod_reg[2]) + (SUM_W'(offset_reg) <<< COORD_FRAC);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_sum) begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // A distance of exactly zero counts as outside.
    assign distance = DIST_W'(sum_a_reg) + DIST_W'(sum_b_reg);
    assign above    = !distance[DIST_W-1] && (distance != '0);

endmodule

/* hw/rtl/frustum_aabb_cull_test.sv */
// A box accepted on s_ passes each register stage listed below, in order, up to the output register.
// Throughput: one box per cycle while m_tready does not stall; the six plane datapaths are fully pipelined
// (input, vertex, multiply, partial-sum and output registers, 18 multipliers).
// Backpressure on m_tready stalls the pipeline stage by stage, bubbles are squeezed out.
// Reset: synchronous active-low aresetn empties the pipeline and loads the
// identity matrix into the four row registers.
module frustum_aabb_cull_test
    import fac_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    localparam int S_FIELD_BITS = 3 * COORD_WIDTH + 3 * (COORD_WIDTH - 1),
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ROW_BITS-1:0]       cfg_wdata,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, zero fill
    input  logic [S_TDATA_BITS-1:0]   s_tdata,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // visible, zero fill
    output logic [M_TDATA_BITS-1:0]   m_tdata
);

    localparam int HALF_W = COORD_WIDTH - 1;
    localparam int V_W    = COORD_WIDTH + 1;

    logic [ROW_BITS-1:0] row_x_reg;
    logic [ROW_BITS-1:0] row_y_reg;
    logic [ROW_BITS-1:0] row_z_reg;
    logic [ROW_BITS-1:0] row_w_reg;

    plane_t plane_next [PLANE_COUNT];
    plane_t plane_reg  [PLANE_COUNT];

    logic signed [COORD_WIDTH-1:0] center_reg [AXES];
    logic        [HALF_W-1:0]      half_reg   [AXES];
    logic signed [V_W-1:0]         vp_next    [AXES];
    logic signed [V_W-1:0]         vm_next    [AXES];
    logic signed [V_W-1:0]         vp_reg     [AXES];
    logic signed [V_W-1:0]         vm_reg     [AXES];

    logic valid0_reg;
    logic valid1_reg;
    logic valid2_reg;
    logic valid3_reg;
    logic m_valid_reg;
    logic visible_reg;

    logic load0;
    logic load1;
    logic load2;
    logic load3;
    logic load_out;

    logic [PLANE_COUNT-1:0] above;
    pipe_ctrl_t             ctrl;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg <= ROW_X_RESET;
            row_y_reg <= ROW_Y_RESET;
            row_z_reg <= ROW_Z_RESET;
            row_w_reg <= ROW_W_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROW_X: row_x_reg <= cfg_wdata;
                CFG_ROW_Y: row_y_reg <= cfg_wdata;
                CFG_ROW_Z: row_z_reg <= cfg_wdata;
                CFG_ROW_W: row_w_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Planes in order: w+z, w-z, w+x, w-x, w+y, w-y. They are refreshed every cycle
    // into plane_reg; a box passes its input and vertex registers before it reaches the multipliers.
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int k = 0; k < ROW_ENTRIES; k++) begin
                if (p < 2) begin
                    plane_next[p][k] = plane_coef(row_w_reg, row_z_reg, 2'(k), (p % 2) == 0);
                end else if (p < 4) begin
                    plane_next[p][k] = plane_coef(row_w_reg, row_x_reg, 2'(k), (p % 2) == 0);
                end else begin
                    plane_next[p][k] = plane_coef(row_w_reg, row_y_reg, 2'(k), (p % 2) == 0);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        plane_reg <= plane_next;
    end

    // Each stage loads when it is empty or when its content moves on.
    assign load_out = !m_valid_reg || m_tready;
    assign load3    = !valid3_reg || load_out;
    assign load2    = !valid2_reg || load3;
    assign load1    = !valid1_reg || load2;
    assign load0    = !valid0_reg || load1;
    assign s_tready = load0;

    assign ctrl.load_mul = load2;
    assign ctrl.load_sum = load3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg  <= 1'b0;
            valid1_reg  <= 1'b0;
            valid2_reg  <= 1'b0;
            valid3_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load0) begin
                valid0_reg <= s_tvalid;
            end
            if (load1) begin
                valid1_reg <= valid0_reg;
            end
            if (load2) begin
                valid2_reg <= valid1_reg;
            end
            if (load3) begin
                valid3_reg <= valid2_reg;
            end
            if (load_out) begin
                m_valid_reg <= valid3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load0) begin
            for (int k = 0; k < AXES; k++) begin
                center_reg[k] <= $signed(s_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
                half_reg[k]   <= s_tdata[AXES*COORD_WIDTH + k*HALF_W +: HALF_W];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            vp_next[k] = V_W'(center_reg[k]) + V_W'($signed({1'b0, half_reg[k]}));
            vm_next[k] = V_W'(center_reg[k]) - V_W'($signed({1'b0, half_reg[k]}));
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            vp_reg <= vp_next;
            vm_reg <= vm_next;
        end
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
        fac_plane #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_plane (
            .aclk  (aclk),
            .ctrl  (ctrl),
            .normal(plane_reg[g]),
            .vp    (vp_reg),
            .vm    (vm_reg),
            .above (above[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            visible_reg <= &above;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS-1){1'b0}}, visible_reg};

endmodule

/* hw/rtl/fac_port_checker.sv */
module fac_port_checker
    import fac_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);

    // Input register, vertex, multiply, partial-sum and output stages.
    localparam int MAX_IN_FLIGHT = 5;

    logic [3:0] in_flight_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg <= '0;
        end else begin
            in_flight_reg <= in_flight_reg + 4'(in_xfer) - 4'(out_xfer);
        end
    end

    a_reset_empties : assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_no_invented : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_flight_reg == '0) |-> !m_tvalid)
        else $error("result presented with no box in flight");

    a_capacity : assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight_reg <= 4'(MAX_IN_FLIGHT))
        else $error("more boxes in flight than pipeline stages");

    a_fill_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_BITS-1:1] == '0))
        else $error("fill bits of m_tdata are not zero");

    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

endmodule

bind frustum_aabb_cull_test fac_port_checker u_fac_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

/* sim/frustum_aabb_cull_checker.sv */
`timescale 1ns / 1ps

module frustum_aabb_cull_checker
    import fac_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    localparam int S_FIELD_BITS = 3 * COORD_WIDTH + 3 * (COORD_WIDTH - 1),
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  cfg_index_t              cfg_index,
    input  logic [ROW_BITS-1:0]     cfg_wdata,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_BITS-1:0] m_tdata,
    output int                      fail_count,
    output int                      outstanding,
    output int                      boxes_checked,
    output int                      visible_count
);

    logic [ROW_BITS-1:0] clip_rows [ROW_ENTRIES];
    bit                  verdict_q [$];
    bit                  want_visible;

    initial begin
        fail_count    = 0;
        outstanding   = 0;
        boxes_checked = 0;
        visible_count = 0;
    end

    // A box survives only if its positive vertex lies strictly inside all six planes.
    function automatic bit box_in_view(input logic [S_TDATA_BITS-1:0] box);
        longint                       ctr [AXES];
        longint                       ext [AXES];
        longint                       coef [ROW_ENTRIES];
        longint                       plane_dist;
        longint                       vert;
        logic [ROW_BITS-1:0]          side;
        logic signed [ENTRY_BITS-1:0] w_ent;
        logic signed [ENTRY_BITS-1:0] o_ent;
        bit                           in_view;
        in_view = 1'b1;
        for (int k = 0; k < AXES; k++) begin
            ctr[k] = longint'($signed(box[k*COORD_WIDTH +: COORD_WIDTH]));
            ext[k] = longint'(box[3*COORD_WIDTH + k*(COORD_WIDTH-1) +: COORD_WIDTH-1]);
        end
        for (int p = 0; p < PLANE_COUNT; p++) begin
            case (p / 2)
                0: side = clip_rows[CFG_ROW_Z];
                1: side = clip_rows[CFG_ROW_X];
                default: side = clip_rows[CFG_ROW_Y];
            endcase
            for (int c = 0; c < ROW_ENTRIES; c++) begin
                w_ent = clip_rows[CFG_ROW_W][c*ENTRY_BITS +: ENTRY_BITS];
                o_ent = side[c*ENTRY_BITS +: ENTRY_BITS];
                if (p % 2 == 0) begin
                    coef[c] = longint'(w_ent) + longint'(o_ent);
                end else begin
                    coef[c] = longint'(w_ent) - longint'(o_ent);
                end
            end
            // The offset is aligned with the fractional bits of the coordinates.
            plane_dist = coef[3] * (longint'(1) << COORD_FRAC);
            for (int k = 0; k < AXES; k++) begin
                vert = (coef[k] < 0) ? ctr[k] - ext[k] : ctr[k] + ext[k];
                plane_dist = plane_dist + coef[k] * vert;
            end
            if (plane_dist <= 0) begin
                in_view = 1'b0;
            end
        end
        return in_view;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clip_rows[CFG_ROW_X] <= ROW_X_RESET;
            clip_rows[CFG_ROW_Y] <= ROW_Y_RESET;
            clip_rows[CFG_ROW_Z] <= ROW_Z_RESET;
            clip_rows[CFG_ROW_W] <= ROW_W_RESET;
            verdict_q.delete();
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                clip_rows[cfg_index] <= cfg_wdata;
            end
            // Retire the result first so that a box accepted at this edge cannot match it.
            if (m_tvalid && m_tready) begin
                boxes_checked++;
                if (m_tdata[0]) begin
                    visible_count++;
                end
                if (verdict_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: result transaction with no box outstanding, visible=%0b",
                                 $time, m_tdata[0]);
                    end
                    fail_count++;
                end else begin
                    want_visible = verdict_q.pop_front();
                    if (want_visible != m_tdata[0]) begin
                        if (fail_count < 10) begin
                            $display("%0t: visible mismatch, expected %0b, got %0b",
                                     $time, want_visible, m_tdata[0]);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                verdict_q.push_back(box_in_view(s_tdata));
            end
            outstanding <= verdict_q.size();
        end
    end

endmodule

/* sim/tb_frustum_aabb_cull_test.sv */
`timescale 1ns / 1ps

module tb_frustum_aabb_cull_test;
    import fac_pkg::*;

    localparam int COORD_WIDTH  = 24;
    localparam int S_FIELD_BITS = 3 * COORD_WIDTH + 3 * (COORD_WIDTH - 1);
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int FILL_BITS    = S_TDATA_BITS - S_FIELD_BITS;
    localparam int MAX_CENTER   = 8388607;
    localparam int MIN_CENTER   = -8388608;
    localparam int MAX_HALF     = 8388607;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;

    // Field order matches s_tdata, center_x in the lowest bits.
    typedef struct packed {
        logic [FILL_BITS-1:0]          fill;
        logic [COORD_WIDTH-2:0]        half_z;
        logic [COORD_WIDTH-2:0]        half_y;
        logic [COORD_WIDTH-2:0]        half_x;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_x;
    } box_t;

    typedef logic [ROW_ENTRIES-1:0][ROW_BITS-1:0] matrix_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    cfg_index_t              cfg_index = CFG_ROW_X;
    logic [ROW_BITS-1:0]     cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    hold_go   = 1'b0;

    int fail_count;
    int outstanding;
    int boxes_checked;
    int visible_count;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int matrix_count  = 1;

    frustum_aabb_cull_test #(.COORD_WIDTH(COORD_WIDTH)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    frustum_aabb_cull_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .boxes_checked (boxes_checked),
        .visible_count (visible_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
    always @(posedge aclk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        m_tready <= !hold_go && hold_left <= 1 && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d results still outstanding",
                     $time, cycle_count, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one box, with random idle cycles ahead of it, and waits for the transaction.
    task automatic send_box(input int cx, input int cy, input int cz,
                            input int hx, input int hy, input int hz);
        box_t b;
        b.fill     = '0;
        b.center_x = COORD_WIDTH'(cx);
        b.center_y = COORD_WIDTH'(cy);
        b.center_z = COORD_WIDTH'(cz);
        b.half_x   = (COORD_WIDTH-1)'(hx);
        b.half_y   = (COORD_WIDTH-1)'(hy);
        b.half_z   = (COORD_WIDTH-1)'(hz);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [ROW_BITS-1:0] rand_row(input int mag);
        logic [ROW_BITS-1:0] row;
        for (int c = 0; c < ROW_ENTRIES; c++) begin
            row[c*ENTRY_BITS +: ENTRY_BITS] = ENTRY_BITS'(int'($urandom_range(0, 2 * mag)) - mag);
        end
        return row;
    endfunction

    task automatic run_phase(input matrix_t m, input bit load, input int items,
                             input int tx_pct, input int rx_pct, input bit hold);
        int c [AXES];
        int h [AXES];
        int mode;
        int scale;
        wait_for_drain();
        if (load) begin
            for (int r = 0; r < ROW_ENTRIES; r++) begin
                cfg_we    <= 1'b1;
                cfg_index <= cfg_index_t'(r);
                cfg_wdata <= m[r];
                @(posedge aclk);
            end
            cfg_we <= 1'b0;
            matrix_count++;
        end
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold) begin
            hold_go <= 1'b1;
            @(posedge aclk);
            hold_go <= 1'b0;
        end
        for (int i = 0; i < items; i++) begin
            // Halfway through, the sender pauses until every result is back.
            if (i == items / 2) begin
                wait_for_drain();
            end
            mode = $urandom_range(0, 9);
            for (int k = 0; k < AXES; k++) begin
                if (mode < 6) begin
                    // Boxes around the view volume at a random scale.
                    scale = $urandom_range(6, 14);
                    c[k] = int'($urandom_range(0, 2 << scale)) - (1 << scale);
                    h[k] = $urandom_range(0, 1 << (scale - 1));
                end else if (mode < 8) begin
                    c[k] = $urandom;
                    h[k] = $urandom;
                end else begin
                    // Close to the unit planes, where distances come out near zero.
                    c[k] = ($urandom_range(0, 1) ? 256 : -256) + int'($urandom_range(0, 8)) - 4;
                    h[k] = $urandom_range(0, 4);
                end
            end
            send_box(c[0], c[1], c[2], h[0], h[1], h[2]);
        end
    endtask

    initial begin
        matrix_t m;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity matrix after reset: field extremes and boxes that touch a plane.
        send_box(0, 0, 0, 0, 0, 0);
        send_box(MAX_CENTER, MAX_CENTER, MAX_CENTER, 0, 0, 0);
        send_box(MIN_CENTER, MIN_CENTER, MIN_CENTER, 0, 0, 0);
        send_box(MAX_CENTER, MAX_CENTER, MAX_CENTER, MAX_HALF, MAX_HALF, MAX_HALF);
        send_box(MIN_CENTER, MIN_CENTER, MIN_CENTER, MAX_HALF, MAX_HALF, MAX_HALF);
        send_box(0, 0, 0, MAX_HALF, MAX_HALF, MAX_HALF);
        send_box(0, 0, -256, 0, 0, 0);
        send_box(0, 0, -257, 0, 0, 1);
        send_box(0, 0, -257, 0, 0, 2);
        send_box(256, 0, 0, 0, 0, 0);
        send_box(300, 0, 0, 44, 0, 0);
        send_box(300, 0, 0, 45, 0, 0);
        send_box(0, -256, 0, 0, 0, 0);
        send_box(0, 255, 0, 0, 0, 0);
        send_box(5592405, -5592406, 5592405, 2796202, 5592405, 2796202);
        send_box(-5592406, 5592405, -5592406, 5592405, 2796202, 5592405);
        run_phase('0, 1'b0, 150, 0, 0, 1'b0);

        m[CFG_ROW_X] = rand_row(512);
        m[CFG_ROW_Y] = rand_row(512);
        m[CFG_ROW_Z] = rand_row(512);
        m[CFG_ROW_W] = rand_row(512);
        run_phase(m, 1'b1, 300, 75, 0, 1'b0);

        // Largest and smallest entries, all-ones and all-zeros registers.
        m[CFG_ROW_X] = 64'h7FFF_7FFF_7FFF_7FFF;
        m[CFG_ROW_Y] = 64'h8000_8000_8000_8000;
        m[CFG_ROW_Z] = 64'hFFFF_FFFF_FFFF_FFFF;
        m[CFG_ROW_W] = 64'h0000_0000_0000_0000;
        run_phase(m, 1'b1, 150, 0, 75, 1'b0);

        // A zero matrix makes every plane degenerate, so every box is culled.
        run_phase('0, 1'b1, 30, 10, 10, 1'b0);

        // Perspective-like projection looking down negative z.
        m[CFG_ROW_X] = 64'h0000_0000_0000_0180;
        m[CFG_ROW_Y] = 64'h0000_0000_0180_0000;
        m[CFG_ROW_Z] = 64'hFE00_FEFF_0000_0000;
        m[CFG_ROW_W] = 64'h0000_FF00_0000_0000;
        run_phase(m, 1'b1, 300, 0, 0, 1'b1);

        m[CFG_ROW_X] = {$urandom, $urandom};
        m[CFG_ROW_Y] = {$urandom, $urandom};
        m[CFG_ROW_Z] = {$urandom, $urandom};
        m[CFG_ROW_W] = {$urandom, $urandom};
        run_phase(m, 1'b1, 300, 10, 10, 1'b0);

        m[CFG_ROW_X] = ROW_X_RESET;
        m[CFG_ROW_Y] = ROW_Y_RESET;
        m[CFG_ROW_Z] = ROW_Z_RESET;
        m[CFG_ROW_W] = ROW_W_RESET;
        run_phase(m, 1'b1, 300, 0, 75, 1'b0);

        wait_for_drain();
        repeat (10) @(posedge aclk);

        $display("Checked %0d boxes (%0d visible, %0d culled) under %0d matrix settings.",
                 boxes_checked, visible_count, boxes_checked - visible_count, matrix_count);
        $display("Idle patterns: none, sender-heavy, receiver-heavy, mixed, plus a long hold-off.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fac_pkg.sv
hw/rtl/fac_plane.sv
hw/rtl/frustum_aabb_cull_test.sv
hw/rtl/fac_port_checker.sv
sim/frustum_aabb_cull_checker.sv
sim/tb_frustum_aabb_cull_test.sv
